>>> rtl/rmo_pkg.sv
// Shared types and constants of the region moment and orientation unit.
// Depends on nothing; every other file takes names from here by scope.
`default_nettype none
package rmo_pkg;

    localparam int PIX_W    = 8;
    localparam int COORD_W  = 11;
    localparam int DIM_W    = 8;
    localparam int CENT_W   = 19;
    localparam int DIR_W    = 16;
    localparam int MEAN_W   = 16;
    localparam int MASS_W   = 22;
    localparam int M1_W     = 30;
    localparam int M2_W     = 37;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_Y    = 3'd5;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NO_MASS = 2'd2
    } t_status;

    // arctangent of 2^-i in Q30 radians, truncated
    localparam int ATAN_LEN = 24;
    localparam int ITER_W   = 5;
    localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};

    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [63:0] Q30_GAIN    = 64'sd652032874;

endpackage
`default_nettype wire

>>> rtl/rmo_ifs.sv
// Valid/ready channel interfaces: pixel items in, result items out.
// Depends on rmo_pkg for field widths.
`default_nettype none
interface rmo_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [rmo_pkg::PIX_W-1:0]  pixel;
    logic                       last;
    modport source (output valid, pixel, last, input ready);
    modport sink   (input valid, pixel, last, output ready);
endinterface

interface rmo_result_if;
    logic                               valid;
    logic                               ready;
    logic        [rmo_pkg::CENT_W-1:0]  centroid_x;
    logic        [rmo_pkg::CENT_W-1:0]  centroid_y;
    logic signed [rmo_pkg::DIR_W-1:0]   direction_x;
    logic signed [rmo_pkg::DIR_W-1:0]   direction_y;
    logic        [rmo_pkg::MEAN_W-1:0]  mean_level;
    logic        [1:0]                  status;
    modport source (output valid, centroid_x, centroid_y, direction_x, direction_y,
                    mean_level, status, input ready);
    modport sink   (input valid, centroid_x, centroid_y, direction_x, direction_y,
                    mean_level, status, output ready);
endinterface
`default_nettype wire

>>> rtl/rmo_cordic.sv
// Iterative CORDIC: normalizes (x, y), finds atan2 by vectoring, halves the
// angle and rotates back to cos/sin in Q1.F. Depends on rmo_pkg.
`default_nettype none
module rmo_cordic #(
    parameter int ANGLE_ITERATIONS    = 16,
    parameter int DIRECTION_FRAC_BITS = 14
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [63:0]                i_x,
    input  wire logic signed [63:0]                i_y,
    output logic                                   o_done,
    output logic signed [rmo_pkg::DIR_W-1:0]       o_cos,
    output logic signed [rmo_pkg::DIR_W-1:0]       o_sin
);
    localparam int SHIFT = 30 - DIRECTION_FRAC_BITS;
    localparam logic signed [63:0] ONE   = 64'sd1 <<< DIRECTION_FRAC_BITS;
    localparam logic signed [63:0] HALF  = 64'sd1 <<< (SHIFT - 1);
    localparam logic signed [63:0] F_MAX = 64'sd32767;
    localparam logic signed [63:0] F_MIN = -64'sd32768;
    localparam logic [63:0] NORM_HI = 64'h0000_0100_0000_0000;
    localparam logic [63:0] NORM_LO = 64'h0000_0080_0000_0000;
    localparam logic [rmo_pkg::ITER_W-1:0] LAST_I = rmo_pkg::ITER_W'(ANGLE_ITERATIONS - 1);

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_NORM = 5'b00010,
        C_VEC  = 5'b00100,
        C_ROT  = 5'b01000,
        C_DONE = 5'b10000
    } t_cstate;

    t_cstate r_state, n_state;
    logic signed [63:0] r_x, r_y, n_x, n_y;
    logic signed [33:0] r_z, n_z;
    logic [rmo_pkg::ITER_W-1:0] r_i, n_i;

    logic [63:0]        abs_x, abs_y, mag;
    logic signed [63:0] xs, ys, cx, cy;
    logic signed [33:0] atan, cz;
    logic               neg_dir;

    function automatic logic signed [rmo_pkg::DIR_W-1:0] to_dir(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + HALF) >>> SHIFT;
        if (r > ONE)   r = ONE;
        if (r < -ONE)  r = -ONE;
        if (r > F_MAX) r = F_MAX;
        if (r < F_MIN) r = F_MIN;
        return r[rmo_pkg::DIR_W-1:0];
    endfunction

    always_comb begin
        abs_x   = r_x[63] ? 64'(-r_x) : 64'(r_x);
        abs_y   = r_y[63] ? 64'(-r_y) : 64'(r_y);
        mag     = (abs_x > abs_y) ? abs_x : abs_y;
        xs      = r_x >>> r_i;
        ys      = r_y >>> r_i;
        atan    = $signed({2'b00, rmo_pkg::ATAN_Q30[r_i]});
        // vectoring drives y to zero, rotation drives z to zero
        neg_dir = (r_state == C_VEC) ? r_y[63] : !r_z[33];
        if (neg_dir) begin
            cx = r_x - ys;
            cy = r_y + xs;
            cz = r_z - atan;
        end else begin
            cx = r_x + ys;
            cy = r_y - xs;
            cz = r_z + atan;
        end
    end

    always_comb begin
        n_state = r_state;
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_i = r_i;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    if (i_x == 64'sd0 && i_y == 64'sd0) begin
                        n_x = rmo_pkg::Q30_GAIN;
                        n_y = 64'sd0;
                        n_z = 34'sd0;
                        n_i = '0;
                        n_state = C_ROT;
                    end else begin
                        n_x = i_x;
                        n_y = i_y;
                        n_state = C_NORM;
                    end
                end
            end
            C_NORM: begin
                if (mag >= NORM_HI) begin
                    n_x = r_x >>> 1;
                    n_y = r_y >>> 1;
                end else if (mag < NORM_LO) begin
                    n_x = r_x <<< 1;
                    n_y = r_y <<< 1;
                end else begin
                    n_i = '0;
                    n_z = 34'sd0;
                    // fold the left half plane onto the right
                    if (r_x[63]) begin
                        if (!r_y[63]) begin
                            n_x = r_y;
                            n_y = -r_x;
                            n_z = rmo_pkg::Q30_HALF_PI;
                        end else begin
                            n_x = -r_y;
                            n_y = r_x;
                            n_z = -rmo_pkg::Q30_HALF_PI;
                        end
                    end
                    n_state = C_VEC;
                end
            end
            C_VEC: begin
                n_x = cx;
                n_y = cy;
                n_z = cz;
                n_i = r_i + 1'b1;
                if (r_i == LAST_I) begin
                    n_z = cz >>> 1;
                    n_x = rmo_pkg::Q30_GAIN;
                    n_y = 64'sd0;
                    n_i = '0;
                    n_state = C_ROT;
                end
            end
            C_ROT: begin
                n_x = cx;
                n_y = cy;
                n_z = cz;
                n_i = r_i + 1'b1;
                if (r_i == LAST_I) begin
                    n_state = C_DONE;
                end
            end
            C_DONE: begin
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_i <= n_i;
    end

    assign o_done = (r_state == C_DONE);
    assign o_cos  = to_dir(r_x);
    assign o_sin  = to_dir(r_y);

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_VEC && r_i == '0) |-> (mag < NORM_HI))
        else $error("cordic entered vectoring with an unnormalized vector");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_DONE) |=> (r_state == C_IDLE))
        else $error("cordic did not return to idle after done");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_VEC || r_state == C_ROT) |-> (r_i <= LAST_I))
        else $error("cordic iteration count ran past its end");

endmodule
`default_nettype wire

>>> rtl/roi_moment_orientation_unit.sv
// Top level of the region moment and orientation unit.
// Depends on rmo_pkg, rmo_ifs (channel interfaces) and rmo_cordic.
//
// Pixels of one clipped region enter on i_pixel_ch in raster order, one
// item per cycle while ready is high; each pixel updates the six raw moments
// from a stage-one register. The item with last set closes the region:
// ready drops and a sequencer works through the closing math on shared
// units: a bit-serial multiplier for the central moments (6 products of
// 30 steps), an iterative CORDIC (up to about 40 normalize steps plus two
// passes of ANGLE_ITERATIONS steps) and a restoring divider for the two
// centroid coordinates and the mean (3 quotients of 39 steps). An empty
// region or a zero mass region skips those loops and goes from setup
// straight to done. The result waits in an output register on o_result_ch;
// pixels of the next region are taken while it waits, but the next close
// holds in its done state until it goes. Configuration writes on i_cfg_*
// land at once. Reset clears the registers, the moments and both channels.
`default_nettype none
module roi_moment_orientation_unit #(
    parameter int MAX_REGION_DIM      = 128,
    parameter int DIRECTION_FRAC_BITS = 14,
    parameter int ANGLE_ITERATIONS    = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rmo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rmo_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    rmo_pixel_if.sink                               i_pixel_ch,
    rmo_result_if.source                            o_result_ch
);
    localparam logic [8:0] MAX_DIM = 9'(MAX_REGION_DIM);
    localparam logic signed [rmo_pkg::DIR_W-1:0] DIR_UP =
        (DIRECTION_FRAC_BITS < 15) ? rmo_pkg::DIR_W'(1 << DIRECTION_FRAC_BITS)
                                   : 16'sd32767;
    localparam int MUL_BITS = 30;
    localparam int DIV_BITS = 39;
    localparam logic [4:0] MUL_LAST = 5'(MUL_BITS - 1);
    localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);
    localparam logic [39:0] CENT_MAX = 40'd524287;
    localparam logic [38:0] MEAN_MAX = 39'd65535;

    // multiply program: D = m*xx - xm^2 - m*yy + ym^2, C = m*xy - xm*ym
    localparam logic [2:0] MOP_M_XX  = 3'd0;
    localparam logic [2:0] MOP_XM_XM = 3'd1;
    localparam logic [2:0] MOP_M_YY  = 3'd2;
    localparam logic [2:0] MOP_YM_YM = 3'd3;
    localparam logic [2:0] MOP_M_XY  = 3'd4;
    localparam logic [2:0] MOP_XM_YM = 3'd5;

    localparam logic [1:0] DSEL_CX   = 2'd0;
    localparam logic [1:0] DSEL_CY   = 2'd1;
    localparam logic [1:0] DSEL_MEAN = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_MUL   = 6'b000100,
        S_ANGLE = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [rmo_pkg::COORD_W-1:0] r_region_x, r_region_y;
    logic [rmo_pkg::DIM_W-1:0]   r_region_w, r_region_h;
    logic [rmo_pkg::CENT_W-1:0]  r_fb_x, r_fb_y;

    // accumulation
    logic [rmo_pkg::DIM_W-1:0]  r_col, r_row;
    logic [rmo_pkg::MASS_W-1:0] r_m;
    logic [rmo_pkg::M1_W-1:0]   r_xm, r_ym;
    logic [rmo_pkg::M2_W-1:0]   r_xx, r_yy, r_xy;
    logic        r_s1_valid, r_s1_acc, r_s1_last, r_s1_empty;
    logic [7:0]  r_s1_p, r_s1_x, r_s1_y;
    logic [15:0] r_s1_xp, r_s1_yp;

    // closing math
    logic [63:0] r_mcand, r_d, r_c;
    logic [29:0] r_mplier;
    logic [4:0]  r_mcnt;
    logic [2:0]  r_op;
    logic        r_cord_start;
    logic [15:0] r_area;
    logic [1:0]  r_dsel;
    logic [5:0]  r_dcnt;
    logic [22:0] r_rem;
    logic [38:0] r_quo;
    logic [21:0] r_divisor;

    // result before the output register
    logic [rmo_pkg::CENT_W-1:0]         r_cx, r_cy;
    logic signed [rmo_pkg::DIR_W-1:0]   r_dx, r_dy;
    logic [rmo_pkg::MEAN_W-1:0]         r_mean;
    rmo_pkg::t_status                   r_status;

    // output register
    logic                               r_o_valid;
    logic [rmo_pkg::CENT_W-1:0]         r_out_cx, r_out_cy;
    logic signed [rmo_pkg::DIR_W-1:0]   r_out_dx, r_out_dy;
    logic [rmo_pkg::MEAN_W-1:0]         r_out_mean;
    rmo_pkg::t_status                   r_out_status;

    logic [rmo_pkg::DIM_W-1:0] w_eff, h_eff;
    logic        empty_now, acc_now, accept, can_load, mul_sub;
    logic [8:0]  col_inc;
    logic [2:0]  mul_sel;
    logic [63:0] ld_mcand, mul_tgt, mul_add, mul_sum;
    logic [29:0] ld_mplier;
    logic [1:0]  div_sel;
    logic [38:0] ld_dividend, n_quo;
    logic [21:0] ld_divisor;
    logic [22:0] div_t, n_rem;
    logic        div_ge;
    logic [39:0] cent_sum;
    logic        cord_done;
    logic signed [rmo_pkg::DIR_W-1:0] cord_cos, cord_sin;

    rmo_cordic #(
        .ANGLE_ITERATIONS    (ANGLE_ITERATIONS),
        .DIRECTION_FRAC_BITS (DIRECTION_FRAC_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cord_start),
        .i_x     ($signed(r_d)),
        .i_y     ($signed({r_c[62:0], 1'b0})),
        .o_done  (cord_done),
        .o_cos   (cord_cos),
        .o_sin   (cord_sin)
    );

    // input side
    always_comb begin
        w_eff = ({1'b0, r_region_w} > MAX_DIM) ? MAX_DIM[7:0] : r_region_w;
        h_eff = ({1'b0, r_region_h} > MAX_DIM) ? MAX_DIM[7:0] : r_region_h;
        empty_now = (w_eff == '0) || (h_eff == '0);
        acc_now   = !empty_now && (r_row < h_eff);
        col_inc   = {1'b0, r_col} + 9'd1;
    end

    assign i_pixel_ch.ready = (r_state == S_IDLE) && !(r_s1_valid && r_s1_last);
    assign accept   = i_pixel_ch.valid && i_pixel_ch.ready;
    assign can_load = !r_o_valid || o_result_ch.ready;

    // multiplier operand select
    always_comb begin
        mul_sel = (r_state == S_SETUP) ? MOP_M_XX : (r_op + 3'd1);
        case (mul_sel)
            MOP_M_XX: begin
                ld_mcand = 64'(r_xx);
                ld_mplier = 30'(r_m);
            end
            MOP_XM_XM: begin
                ld_mcand = 64'(r_xm);
                ld_mplier = r_xm;
            end
            MOP_M_YY: begin
                ld_mcand = 64'(r_yy);
                ld_mplier = 30'(r_m);
            end
            MOP_YM_YM: begin
                ld_mcand = 64'(r_ym);
                ld_mplier = r_ym;
            end
            MOP_M_XY: begin
                ld_mcand = 64'(r_xy);
                ld_mplier = 30'(r_m);
            end
            default: begin
                ld_mcand = 64'(r_ym);
                ld_mplier = r_xm;
            end
        endcase
        mul_sub = (r_op == MOP_XM_XM) || (r_op == MOP_M_YY) || (r_op == MOP_XM_YM);
        mul_tgt = (r_op == MOP_M_XY || r_op == MOP_XM_YM) ? r_c : r_d;
        mul_add = r_mplier[0] ? r_mcand : 64'd0;
        mul_sum = mul_sub ? (mul_tgt - mul_add) : (mul_tgt + mul_add);
    end

    // divider operand select and one restoring step
    always_comb begin
        div_sel = (r_state == S_ANGLE) ? DSEL_CX : (r_dsel + 2'd1);
        case (div_sel)
            DSEL_CX: begin
                ld_dividend = 39'({r_xm, 8'd0}) + 39'(r_m >> 1);
                ld_divisor  = r_m;
            end
            DSEL_CY: begin
                ld_dividend = 39'({r_ym, 8'd0}) + 39'(r_m >> 1);
                ld_divisor  = r_m;
            end
            default: begin
                ld_dividend = 39'({r_m, 8'd0}) + 39'(r_area >> 1);
                ld_divisor  = 22'(r_area);
            end
        endcase
        div_t  = {r_rem[21:0], r_quo[38]};
        div_ge = div_t >= {1'b0, r_divisor};
        n_rem  = div_ge ? (div_t - {1'b0, r_divisor}) : div_t;
        n_quo  = {r_quo[37:0], div_ge};
        cent_sum = (r_dsel == DSEL_CX) ? (40'({r_region_x, 8'd0}) + 40'(n_quo))
                                       : (40'({r_region_y, 8'd0}) + 40'(n_quo));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (r_s1_valid && r_s1_last) n_state = S_SETUP;
            S_SETUP: begin
                if (r_s1_empty || r_m == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   if (r_mcnt == MUL_LAST && r_op == MOP_XM_YM) n_state = S_ANGLE;
            S_ANGLE: if (cord_done) n_state = S_DIV;
            S_DIV:   if (r_dcnt == DIV_LAST && r_dsel == DSEL_MEAN) n_state = S_DONE;
            S_DONE:  if (can_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_region_x   <= '0;
            r_region_y   <= '0;
            r_region_w   <= '0;
            r_region_h   <= '0;
            r_fb_x       <= '0;
            r_fb_y       <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_m          <= '0;
            r_xm         <= '0;
            r_ym         <= '0;
            r_xx         <= '0;
            r_yy         <= '0;
            r_xy         <= '0;
            r_s1_valid   <= 1'b0;
            r_cord_start <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_s1_valid   <= accept;
            r_cord_start <= (r_state == S_MUL) && (n_state == S_ANGLE);

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rmo_pkg::REG_REGION_X:      r_region_x <= i_cfg_data[10:0];
                    rmo_pkg::REG_REGION_Y:      r_region_y <= i_cfg_data[10:0];
                    rmo_pkg::REG_REGION_WIDTH:  r_region_w <= i_cfg_data[7:0];
                    rmo_pkg::REG_REGION_HEIGHT: r_region_h <= i_cfg_data[7:0];
                    rmo_pkg::REG_FALLBACK_X:    r_fb_x <= i_cfg_data;
                    rmo_pkg::REG_FALLBACK_Y:    r_fb_y <= i_cfg_data;
                    default: ;
                endcase
            end

            // advance the raster position of the next pixel
            if (accept && acc_now) begin
                if (col_inc >= {1'b0, w_eff}) begin
                    r_col <= '0;
                    r_row <= r_row + 8'd1;
                end else begin
                    r_col <= col_inc[7:0];
                end
            end

            if (r_s1_valid && r_s1_acc) begin
                r_m  <= r_m + 22'(r_s1_p);
                r_xm <= r_xm + 30'(r_s1_xp);
                r_ym <= r_ym + 30'(r_s1_yp);
                r_xx <= r_xx + 37'(24'(r_s1_x) * 24'(r_s1_xp));
                r_yy <= r_yy + 37'(24'(r_s1_y) * 24'(r_s1_yp));
                r_xy <= r_xy + 37'(24'(r_s1_x) * 24'(r_s1_yp));
            end

            if (r_state == S_DONE && can_load) begin
                r_o_valid <= 1'b1;
                r_col <= '0;
                r_row <= '0;
                r_m   <= '0;
                r_xm  <= '0;
                r_ym  <= '0;
                r_xx  <= '0;
                r_yy  <= '0;
                r_xy  <= '0;
            end else if (o_result_ch.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_acc   <= acc_now;
            r_s1_last  <= i_pixel_ch.last;
            r_s1_empty <= empty_now;
            r_s1_p     <= i_pixel_ch.pixel;
            r_s1_x     <= r_col;
            r_s1_y     <= r_row;
            r_s1_xp    <= r_col * i_pixel_ch.pixel;
            r_s1_yp    <= r_row * i_pixel_ch.pixel;
        end

        case (r_state)
            S_SETUP: begin
                r_area <= w_eff * h_eff;
                if (r_s1_empty) begin
                    r_cx     <= r_fb_x;
                    r_cy     <= r_fb_y;
                    r_dx     <= '0;
                    r_dy     <= DIR_UP;
                    r_mean   <= '0;
                    r_status <= rmo_pkg::ST_EMPTY;
                end else if (r_m == '0) begin
                    r_cx     <= {r_region_x, 8'd0};
                    r_cy     <= {r_region_y, 8'd0};
                    r_dx     <= '0;
                    r_dy     <= DIR_UP;
                    r_mean   <= '0;
                    r_status <= rmo_pkg::ST_NO_MASS;
                end else begin
                    r_status <= rmo_pkg::ST_OK;
                end
                r_d      <= '0;
                r_c      <= '0;
                r_op     <= MOP_M_XX;
                r_mcnt   <= '0;
                r_mcand  <= ld_mcand;
                r_mplier <= ld_mplier;
            end
            S_MUL: begin
                if (r_op == MOP_M_XY || r_op == MOP_XM_YM) begin
                    r_c <= mul_sum;
                end else begin
                    r_d <= mul_sum;
                end
                if (r_mcnt == MUL_LAST) begin
                    r_mcnt   <= '0;
                    r_op     <= mul_sel;
                    r_mcand  <= ld_mcand;
                    r_mplier <= ld_mplier;
                end else begin
                    r_mcnt   <= r_mcnt + 5'd1;
                    r_mcand  <= {r_mcand[62:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[29:1]};
                end
            end
            S_ANGLE: begin
                if (cord_done) begin
                    r_dx      <= cord_cos;
                    r_dy      <= cord_sin;
                    r_dsel    <= div_sel;
                    r_dcnt    <= '0;
                    r_rem     <= '0;
                    r_quo     <= ld_dividend;
                    r_divisor <= ld_divisor;
                end
            end
            S_DIV: begin
                if (r_dcnt == DIV_LAST) begin
                    if (r_dsel == DSEL_MEAN) begin
                        r_mean <= (n_quo > MEAN_MAX) ? MEAN_MAX[15:0] : n_quo[15:0];
                    end else if (r_dsel == DSEL_CX) begin
                        r_cx <= (cent_sum > CENT_MAX) ? CENT_MAX[18:0] : cent_sum[18:0];
                    end else begin
                        r_cy <= (cent_sum > CENT_MAX) ? CENT_MAX[18:0] : cent_sum[18:0];
                    end
                    r_dsel    <= div_sel;
                    r_dcnt    <= '0;
                    r_rem     <= '0;
                    r_quo     <= ld_dividend;
                    r_divisor <= ld_divisor;
                end else begin
                    r_dcnt <= r_dcnt + 6'd1;
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                end
            end
            S_DONE: begin
                if (can_load) begin
                    r_out_cx     <= r_cx;
                    r_out_cy     <= r_cy;
                    r_out_dx     <= r_dx;
                    r_out_dy     <= r_dy;
                    r_out_mean   <= r_mean;
                    r_out_status <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_result_ch.valid       = r_o_valid;
    assign o_result_ch.centroid_x  = r_out_cx;
    assign o_result_ch.centroid_y  = r_out_cy;
    assign o_result_ch.direction_x = r_out_dx;
    assign o_result_ch.direction_y = r_out_dy;
    assign o_result_ch.mean_level  = r_out_mean;
    assign o_result_ch.status      = r_out_status;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_divisor}))
        else $error("divider remainder reached the divisor");
    a_cordic_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> (r_state == S_ANGLE))
        else $error("cordic finished outside the angle phase");
    a_empty_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_out_status == rmo_pkg::ST_EMPTY) |-> (r_out_dx == '0))
        else $error("empty region result carries a tilted direction");
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a completed close");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for roi_moment_orientation_unit: directed rows, then random regions.
// Depends on rmo_pkg and rmo_ifs channel interfaces; predicts results no row supplies.
`timescale 1ns / 1ps
module tb_top;

    localparam int DIR_ONE    = 16384;
    localparam int QUIET_CYC  = 450;
    localparam int ITEM_GOAL  = 1500;

    typedef struct packed {
        logic        [rmo_pkg::CENT_W-1:0] cx;
        logic        [rmo_pkg::CENT_W-1:0] cy;
        logic signed [rmo_pkg::DIR_W-1:0]  dx;
        logic signed [rmo_pkg::DIR_W-1:0]  dy;
        logic        [rmo_pkg::MEAN_W-1:0] mean;
        rmo_pkg::t_status                  st;
    } t_region_result;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        logic [rmo_pkg::CFG_IDX_W-1:0]  idx;
        logic [rmo_pkg::CFG_DATA_W-1:0] val;
        logic [rmo_pkg::PIX_W-1:0]      px;
        logic                           lst;
        bit                             typed;
        t_region_result                 r;
    } t_stim_row;

    typedef struct {
        bit             typed;
        t_region_result r;
    } t_item_tag;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [rmo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rmo_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    rmo_pixel_if  pix_ch();
    rmo_result_if res_ch();

    roi_moment_orientation_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pixel_ch  (pix_ch),
        .o_result_ch (res_ch)
    );

    always #4 i_clk = ~i_clk;

    // register mirror and moment accumulators of the predictor
    logic [rmo_pkg::COORD_W-1:0] reg_x, reg_y;
    logic [rmo_pkg::DIM_W-1:0]   reg_w, reg_h;
    logic [rmo_pkg::CENT_W-1:0]  reg_fx, reg_fy;
    logic [rmo_pkg::DIM_W-1:0]   col_pos, row_pos;
    logic [rmo_pkg::MASS_W-1:0]  acc_m00;
    logic [rmo_pkg::M1_W-1:0]    acc_m10, acc_m01;
    logic [rmo_pkg::M2_W-1:0]    acc_m20, acc_m02, acc_m11;

    t_region_result expected_results[$];
    t_item_tag      item_tags[$];
    t_stim_row      rows[$];
    int             mismatches = 0;
    int             items_sent = 0;
    int             src_idle = 0;
    int             snk_idle = 0;

    function automatic t_region_result make_result(logic [rmo_pkg::CENT_W-1:0] cx,
            logic [rmo_pkg::CENT_W-1:0] cy, int dx, int dy, int mean, rmo_pkg::t_status st);
        t_region_result r;
        r.cx = cx; r.cy = cy; r.dx = dx[rmo_pkg::DIR_W-1:0]; r.dy = dy[rmo_pkg::DIR_W-1:0];
        r.mean = mean[rmo_pkg::MEAN_W-1:0]; r.st = st;
        return r;
    endfunction

    function automatic longint to_direction(longint q30);
        longint r;
        r = (q30 + 64'sd32768) >>> 16;
        if (r > DIR_ONE) r = DIR_ONE;
        if (r < -DIR_ONE) r = -DIR_ONE;
        return r;
    endfunction

    function automatic longint atan_entry(int i);
        return longint'({32'b0, rmo_pkg::ATAN_Q30[i]});
    endfunction

    // vector the doubled angle onto the x axis, halve it, rotate back out
    task automatic half_angle(input longint x0, input longint y0,
                              output longint c, output longint s);
        longint x, y, z, t, nx, ny;
        longint unsigned ax, ay, mg;
        bit done;
        x = x0; y = y0; z = 0; done = 0;
        if (x != 0 || y != 0) begin
            for (int g = 0; g < 70 && !done; g++) begin
                ax = (x < 0) ? -x : x;
                ay = (y < 0) ? -y : y;
                mg = (ax > ay) ? ax : ay;
                if (mg >= (64'd1 << 40)) begin
                    x = x >>> 1; y = y >>> 1;
                end else if (mg < (64'd1 << 39)) begin
                    x = x * 2; y = y * 2;
                end else begin
                    done = 1;
                end
            end
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = rmo_pkg::Q30_HALF_PI;
                end else begin
                    t = x; x = -y; y = t; z = -rmo_pkg::Q30_HALF_PI;
                end
            end
            for (int i = 0; i < 16; i++) begin
                if (y < 0) begin
                    nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_entry(i);
                end else begin
                    nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_entry(i);
                end
                x = nx; y = ny;
            end
        end
        z = z >>> 1;
        x = rmo_pkg::Q30_GAIN;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_entry(i);
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_entry(i);
            end
            x = nx; y = ny;
        end
        c = to_direction(x);
        s = to_direction(y);
    endtask

    function automatic logic [rmo_pkg::CENT_W-1:0] centroid_coord(logic [63:0] off,
            logic [63:0] mom, logic [63:0] mass);
        logic [63:0] v;
        v = (off << 8) + ((mom << 8) + mass / 2) / mass;
        return (v > 64'd524287) ? rmo_pkg::CENT_W'(524287) : v[rmo_pkg::CENT_W-1:0];
    endfunction

    task automatic clear_moments();
        col_pos = 0; row_pos = 0;
        acc_m00 = 0; acc_m10 = 0; acc_m01 = 0; acc_m20 = 0; acc_m02 = 0; acc_m11 = 0;
    endtask

    task automatic predict_pixel(input logic [rmo_pkg::PIX_W-1:0] p, input logic lst,
                                 output bit got, output t_region_result r);
        logic [63:0] w, h, px, cx, cy, mm, s10, s01, a, b, c, area, mean;
        longint dx, dy;
        got = 0;
        r = '0;
        w = (reg_w > 128) ? 64'd128 : 64'(reg_w);
        h = (reg_h > 128) ? 64'd128 : 64'(reg_h);
        if (w == 0 || h == 0) begin
            if (lst) begin
                got = 1;
                r = make_result(reg_fx, reg_fy, 0, DIR_ONE, 0, rmo_pkg::ST_EMPTY);
                clear_moments();
            end
        end else begin
            if (64'(row_pos) < h) begin
                px = p; cx = col_pos; cy = row_pos;
                acc_m00 = acc_m00 + rmo_pkg::MASS_W'(px);
                acc_m10 = acc_m10 + rmo_pkg::M1_W'(cx * px);
                acc_m01 = acc_m01 + rmo_pkg::M1_W'(cy * px);
                acc_m20 = acc_m20 + rmo_pkg::M2_W'(cx * cx * px);
                acc_m02 = acc_m02 + rmo_pkg::M2_W'(cy * cy * px);
                acc_m11 = acc_m11 + rmo_pkg::M2_W'(cx * cy * px);
                col_pos = col_pos + 1;
                if (64'(col_pos) >= w) begin
                    col_pos = 0;
                    row_pos = row_pos + 1;
                end
            end
            if (lst) begin
                got = 1;
                if (acc_m00 == 0) begin
                    r = make_result({reg_x, 8'd0}, {reg_y, 8'd0}, 0, DIR_ONE, 0,
                                    rmo_pkg::ST_NO_MASS);
                end else begin
                    mm = acc_m00; s10 = acc_m10; s01 = acc_m01;
                    a = mm * 64'(acc_m20) - s10 * s10;
                    b = mm * 64'(acc_m02) - s01 * s01;
                    c = mm * 64'(acc_m11) - s10 * s01;
                    area = w * h;
                    mean = ((mm << 8) + area / 2) / area;
                    if (mean > 64'd65535) mean = 64'd65535;
                    half_angle(longint'(a - b), longint'(c * 2), dx, dy);
                    r.cx = centroid_coord(64'(reg_x), s10, mm);
                    r.cy = centroid_coord(64'(reg_y), s01, mm);
                    r.dx = dx[rmo_pkg::DIR_W-1:0];
                    r.dy = dy[rmo_pkg::DIR_W-1:0];
                    r.mean = mean[rmo_pkg::MEAN_W-1:0];
                    r.st = rmo_pkg::ST_OK;
                end
                clear_moments();
            end
        end
    endtask

    // pixel side: tag each accepted item and predict from it
    always @(posedge i_clk) begin
        t_item_tag      tag;
        t_region_result r;
        bit             got;
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            tag = item_tags.pop_front();
            predict_pixel(pix_ch.pixel, pix_ch.last, got, r);
            if (tag.typed)
                expected_results.push_back(tag.r);
            else if (got)
                expected_results.push_back(r);
        end
    end

    // result side: compare against the oldest expectation
    always @(posedge i_clk) begin
        t_region_result e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cx=%0d cy=%0d dx=%0d dy=%0d mean=%0d st=%0d",
                             res_ch.centroid_x, res_ch.centroid_y, res_ch.direction_x,
                             res_ch.direction_y, res_ch.mean_level, res_ch.status);
            end else begin
                e = expected_results.pop_front();
                if (res_ch.centroid_x !== e.cx || res_ch.centroid_y !== e.cy ||
                    res_ch.direction_x !== e.dx || res_ch.direction_y !== e.dy ||
                    res_ch.mean_level !== e.mean || res_ch.status !== e.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp cx=%0d cy=%0d dx=%0d dy=%0d mean=%0d st=%0d",
                                 e.cx, e.cy, e.dx, e.dy, e.mean, e.st,
                                 " got cx=%0d cy=%0d dx=%0d dy=%0d mean=%0d st=%0d",
                                 res_ch.centroid_x, res_ch.centroid_y, res_ch.direction_x,
                                 res_ch.direction_y, res_ch.mean_level, res_ch.status);
                end
            end
        end
    end

    always @(negedge i_clk)
        res_ch.ready = ($urandom_range(99) >= snk_idle);

    task automatic send_item(input logic [rmo_pkg::PIX_W-1:0] p, input logic lst,
                             input bit typed, input t_region_result r);
        t_item_tag tag;
        while ($urandom_range(99) < src_idle) begin
            pix_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        tag.typed = typed;
        tag.r = r;
        item_tags.push_back(tag);
        pix_ch.valid = 1'b1;
        pix_ch.pixel = p;
        pix_ch.last  = lst;
        do @(posedge i_clk); while (!pix_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // hold until every result is out and any close in progress has drained
    task automatic wait_quiet();
        pix_ch.valid = 1'b0;
        while (expected_results.size() != 0 || item_tags.size() != 0)
            @(negedge i_clk);
        repeat (QUIET_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rmo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rmo_pkg::CFG_DATA_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            rmo_pkg::REG_REGION_X:      reg_x  = val[rmo_pkg::COORD_W-1:0];
            rmo_pkg::REG_REGION_Y:      reg_y  = val[rmo_pkg::COORD_W-1:0];
            rmo_pkg::REG_REGION_WIDTH:  reg_w  = val[rmo_pkg::DIM_W-1:0];
            rmo_pkg::REG_REGION_HEIGHT: reg_h  = val[rmo_pkg::DIM_W-1:0];
            rmo_pkg::REG_FALLBACK_X:    reg_fx = val;
            rmo_pkg::REG_FALLBACK_Y:    reg_fy = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic add_cfg(input logic [rmo_pkg::CFG_IDX_W-1:0] idx, input int val);
        t_stim_row s;
        s = '{ROW_CFG, idx, val[rmo_pkg::CFG_DATA_W-1:0], '0, 1'b0, 0, '0};
        rows.push_back(s);
    endtask

    task automatic add_item(input int p, input logic lst, input bit typed = 0,
                            input t_region_result r = '0);
        t_stim_row s;
        s = '{ROW_ITEM, '0, '0, p[rmo_pkg::PIX_W-1:0], lst, typed, r};
        rows.push_back(s);
    endtask

    function automatic logic [rmo_pkg::PIX_W-1:0] pick_pixel(int mode);
        case (mode)
            0: return 8'($urandom_range(255));
            1: return 8'd255;
            2: return ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
            default: return 8'($urandom_range(200, 255));
        endcase
    endfunction

    task automatic random_config();
        int w, h;
        case ($urandom_range(19))
            0: begin w = 0; h = $urandom_range(0, 5); end
            1: begin w = $urandom_range(1, 5); h = 0; end
            2: begin w = 128; h = $urandom_range(1, 2); end
            3: begin w = $urandom_range(1, 2); h = 128; end
            default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 6); end
        endcase
        write_reg(rmo_pkg::REG_REGION_WIDTH, rmo_pkg::CFG_DATA_W'(w));
        write_reg(rmo_pkg::REG_REGION_HEIGHT, rmo_pkg::CFG_DATA_W'(h));
        write_reg(rmo_pkg::REG_REGION_X, rmo_pkg::CFG_DATA_W'(
                  ($urandom_range(3) == 0) ? 2047 : $urandom_range(2047)));
        write_reg(rmo_pkg::REG_REGION_Y, rmo_pkg::CFG_DATA_W'(
                  ($urandom_range(3) == 0) ? 2047 : $urandom_range(2047)));
        write_reg(rmo_pkg::REG_FALLBACK_X, rmo_pkg::CFG_DATA_W'($urandom_range(524287)));
        write_reg(rmo_pkg::REG_FALLBACK_Y, rmo_pkg::CFG_DATA_W'($urandom_range(524287)));
    endtask

    task automatic random_region();
        int n, area, kind, mode;
        t_region_result none;
        none = '0;
        area = ((reg_w > 128) ? 128 : reg_w) * ((reg_h > 128) ? 128 : reg_h);
        kind = $urandom_range(99);
        mode = $urandom_range(3);
        if (kind < 10) mode = 2;
        if (area == 0) begin
            // ignored items, then the one that closes the empty region
            n = $urandom_range(0, 3);
            repeat (n) send_item(8'($urandom_range(255)), 1'b0, 0, none);
            send_item(8'($urandom_range(255)), 1'b1, 0, none);
        end else if (kind < 15) begin
            repeat (area) send_item(8'd0, 1'b0, 0, none);
            send_item(8'd0, 1'b1, 0, none);
        end else if (kind < 25) begin
            n = $urandom_range(1, area);
            for (int i = 1; i < n; i++) send_item(pick_pixel(mode), 1'b0, 0, none);
            send_item(pick_pixel(mode), 1'b1, 0, none);
        end else if (kind < 33) begin
            n = area + $urandom_range(1, 4);
            for (int i = 1; i < n; i++) send_item(pick_pixel(mode), 1'b0, 0, none);
            send_item(pick_pixel(mode), 1'b1, 0, none);
        end else begin
            for (int i = 1; i < area; i++) send_item(pick_pixel(mode), 1'b0, 0, none);
            send_item(pick_pixel(mode), 1'b1, 0, none);
        end
    endtask

    initial begin
        int phase;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        pix_ch.last  = 1'b0;
        res_ch.ready = 1'b0;
        reg_x = 0; reg_y = 0; reg_w = 0; reg_h = 0; reg_fx = 0; reg_fy = 0;
        clear_moments();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty region right after reset returns the zero fallback
        add_item(255, 1'b0);
        add_item(0, 1'b1, 1, make_result(0, 0, 0, DIR_ONE, 0, rmo_pkg::ST_EMPTY));
        add_cfg(rmo_pkg::REG_FALLBACK_X, 524287);
        add_cfg(rmo_pkg::REG_FALLBACK_Y, 524287);
        add_item(7, 1'b1, 1, make_result(524287, 524287, 0, DIR_ONE, 0, rmo_pkg::ST_EMPTY));
        add_cfg(rmo_pkg::REG_REGION_X, 2047);
        add_cfg(rmo_pkg::REG_REGION_Y, 2047);
        add_cfg(rmo_pkg::REG_REGION_WIDTH, 2);
        add_cfg(rmo_pkg::REG_REGION_HEIGHT, 2);
        // zero mass lands on the region offset
        add_item(0, 1'b0); add_item(0, 1'b0); add_item(0, 1'b0);
        add_item(0, 1'b1, 1, make_result(524032, 524032, 0, DIR_ONE, 0, rmo_pkg::ST_NO_MASS));
        // flat bright region: degenerate angle, centroid half a pixel past the offset
        add_item(255, 1'b0); add_item(255, 1'b0); add_item(255, 1'b0); add_item(255, 1'b1);
        // early last
        add_item(9, 1'b1);
        add_cfg(rmo_pkg::REG_REGION_X, 0);
        add_cfg(rmo_pkg::REG_REGION_Y, 0);
        add_cfg(rmo_pkg::REG_REGION_WIDTH, 3);
        // diagonal streak, then excess pixels past the full region
        add_item(255, 1'b0); add_item(0, 1'b0); add_item(0, 1'b0);
        add_item(0, 1'b0); add_item(255, 1'b1);
        add_cfg(rmo_pkg::REG_REGION_WIDTH, 1);
        add_cfg(rmo_pkg::REG_REGION_HEIGHT, 1);
        add_item(200, 1'b0); add_item(100, 1'b0); add_item(50, 1'b1);

        src_idle = 9; snk_idle = 53;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                wait_quiet();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_item(rows[i].px, rows[i].lst, rows[i].typed, rows[i].r);
            end
        end

        items_sent = 0;
        while (items_sent < ITEM_GOAL) begin
            phase = items_sent * 3 / ITEM_GOAL;
            src_idle = (phase == 0) ? 9 : (phase == 1) ? 53 : 0;
            snk_idle = (phase == 0) ? 53 : (phase == 1) ? 9 : 0;
            wait_quiet();
            random_config();
            repeat ($urandom_range(2, 6)) random_region();
        end

        wait_quiet();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rmo_pkg.sv
rtl/rmo_ifs.sv
rtl/rmo_cordic.sv
rtl/roi_moment_orientation_unit.sv
verif/tb_top.sv
